### rtl/tam_pkg.sv
// tam_pkg: shared types and constants for the timestamp anchor mapper
// used by tam_div and timestamp_anchor_mapper; no dependencies
package tam_pkg;

  localparam int TS_W  = 64;
  localparam int DIV_W = 32;
  localparam int CFG_W = 32;

  // item modes
  localparam logic [1:0] MODE_OBSERVE = 2'd0;
  localparam logic [1:0] MODE_CONVERT = 2'd1;
  localparam logic [1:0] MODE_CLEAR   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_UNITS_PER_MS   = 2'd0;
  localparam logic [1:0] REG_FORWARD_JUMP   = 2'd1;
  localparam logic [1:0] REG_BACKWARD_TOL   = 2'd2;

  // configuration reset values
  localparam logic [CFG_W-1:0]        UNITS_PER_MS_RST  = 32'd90;
  localparam logic signed [CFG_W-1:0] FORWARD_JUMP_RST  = 32'sd1000;
  localparam logic signed [CFG_W-1:0] BACKWARD_TOL_RST  = -32'sd200;

  // no anchor / unavailable marker
  localparam logic [TS_W-1:0] TS_NONE = '1;

  typedef struct packed {
    logic [1:0]             mode;
    logic signed [TS_W-1:0] sender_units;
    logic signed [TS_W-1:0] session_now_ms;
    logic                   discontinuity;
    logic                   is_authority;
  } in_item_t;

  typedef struct packed {
    logic signed [TS_W-1:0] session_ms;
    logic                   locked;
    logic                   reanchored;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [TS_W-1:0]   dividend;
    logic [DIV_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [TS_W-1:0]   quotient;
  } div_rsp_t;

endpackage

### rtl/tam_div.sv
// tam_div: iterative signed 64-bit by unsigned 32-bit divider, one quotient bit per cycle
// truncates toward zero; depends on tam_pkg
module tam_div
  import tam_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(TS_W);

  logic [TS_W-1:0]  quo;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             neg;
  logic             run;
  logic             fix;
  logic             done;

  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   diff;
  logic             ge;

  assign shifted = {rem, quo[TS_W-1]};
  assign ge      = shifted >= {1'b0, dvs};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        // divide on the magnitude, sign restored at the end
        neg <= req.dividend[TS_W-1];
        quo <= req.dividend[TS_W-1] ? (~req.dividend + 1'b1) : req.dividend;
        rem <= '0;
        dvs <= (req.divisor == '0) ? DIV_W'(1) : req.divisor;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        rem <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        quo <= {quo[TS_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(TS_W - 1)) begin
          run <= 1'b0;
          fix <= 1'b1;
        end
      end else if (fix) begin
        quo  <= neg ? (~quo + 1'b1) : quo;
        fix  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> (!run && !fix))
    else $error("divider started while busy");

  a_done_after_fix: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(fix))
    else $error("divider done without final sign step");

  a_run_fix_excl: assert property (@(posedge clk) disable iff (rst)
    !(run && fix))
    else $error("divider run and fix both active");

endmodule

### rtl/timestamp_anchor_mapper.sv
// timestamp_anchor_mapper: anchors sender timestamps onto the session ms timeline
// depends on tam_pkg and tam_div
//
// Usage: input items (mode, sender_units, session_now_ms, discontinuity,
// is_authority) arrive on item/item_valid/item_ready; each yields exactly one
// result (session_ms, locked, reanchored) on result/result_valid/result_ready.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must write them
// only while the block is idle; the block itself does not enforce this. Index 0
// units_per_ms, 1 forward_jump_ms, 2 backward_tolerance_ms. An item that needs a
// divide (authority delta check in observe mode, or a locked conversion) passes
// through the prepare, divide and write-back states, the shared divider producing
// one quotient bit per cycle (64 steps plus operand load and sign steps). Other
// items go from accept straight to write-back. One item is in work at a time;
// item_ready is high only while idle, so the next item is not accepted until the
// previous one has left write-back. The result register lets the next item be
// accepted while a result waits; a stalled receiver holds the result and the
// following item waits in write-back until the result register frees.
// Reset clears the anchor (unlocked), the authority history and restores the
// register defaults 90, 1000 and -200.
module timestamp_anchor_mapper
  import tam_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  in_item_t         item,
  output logic             result_valid,
  input  logic             result_ready,
  output out_item_t        result,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_DIV  = 4'b0100,
    S_WB   = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [CFG_W-1:0]        units_per_ms;
  logic signed [CFG_W-1:0] forward_jump_ms;
  logic signed [CFG_W-1:0] backward_tolerance_ms;

  logic [TS_W-1:0] anchor_su;
  logic [TS_W-1:0] anchor_ms;
  logic [TS_W-1:0] last_auth;

  // captured item
  logic [1:0]      op_mode;
  logic [TS_W-1:0] op_su;
  logic [TS_W-1:0] op_now;
  logic            op_auth;
  logic            op_need;
  logic            op_div;
  logic [TS_W-1:0] diff;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic item_fire;
  logic wb_fire;
  logic obs_need;
  logic obs_div;
  logic cnv_div;

  logic [TS_W-1:0] anchor_su_next;
  logic [TS_W-1:0] anchor_ms_next;
  logic [TS_W-1:0] last_auth_next;
  out_item_t       result_next;
  logic            jump;

  assign item_ready = (state == S_IDLE);
  assign item_fire  = item_valid && item_ready;
  assign wb_fire    = (state == S_WB) && (!result_valid || result_ready);

  assign obs_need = anchor_su[TS_W-1] || (item.is_authority && item.discontinuity);
  assign obs_div  = (item.mode == MODE_OBSERVE) && !item.sender_units[TS_W-1] && !obs_need
                    && item.is_authority && !last_auth[TS_W-1];
  assign cnv_div  = (item.mode == MODE_CONVERT) && !anchor_su[TS_W-1]
                    && !item.sender_units[TS_W-1];

  assign div_req.start    = (state == S_PREP);
  assign div_req.dividend = diff;
  assign div_req.divisor  = units_per_ms;

  tam_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // delta window test on the registered quotient
  assign jump = op_div && (
      ($signed(div_rsp.quotient) > $signed({{(TS_W-CFG_W){forward_jump_ms[CFG_W-1]}},
                                            forward_jump_ms}))
   || ($signed(div_rsp.quotient) < $signed({{(TS_W-CFG_W){backward_tolerance_ms[CFG_W-1]}},
                                            backward_tolerance_ms})));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (item_fire) state_next = (obs_div || cnv_div) ? S_PREP : S_WB;
      S_PREP: state_next = S_DIV;
      S_DIV:  if (div_rsp.done) state_next = S_WB;
      S_WB:   if (wb_fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    anchor_su_next         = anchor_su;
    anchor_ms_next         = anchor_ms;
    last_auth_next         = last_auth;
    result_next.session_ms = TS_NONE;
    result_next.reanchored = 1'b0;
    unique case (op_mode)
      MODE_OBSERVE: begin
        if (!op_su[TS_W-1]) begin
          if (op_need || jump) begin
            anchor_su_next         = op_su;
            anchor_ms_next         = op_now;
            result_next.reanchored = 1'b1;
          end
          if (op_auth) last_auth_next = op_su;
        end
      end
      MODE_CONVERT: begin
        if (op_div) result_next.session_ms = anchor_ms + div_rsp.quotient;
      end
      MODE_CLEAR: begin
        anchor_su_next = TS_NONE;
        anchor_ms_next = TS_NONE;
        last_auth_next = TS_NONE;
      end
      default: ;
    endcase
    result_next.locked = !anchor_su_next[TS_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                 <= S_IDLE;
      result_valid          <= 1'b0;
      units_per_ms          <= UNITS_PER_MS_RST;
      forward_jump_ms       <= FORWARD_JUMP_RST;
      backward_tolerance_ms <= BACKWARD_TOL_RST;
      anchor_su             <= TS_NONE;
      anchor_ms             <= TS_NONE;
      last_auth             <= TS_NONE;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_UNITS_PER_MS: units_per_ms          <= cfg_data;
          REG_FORWARD_JUMP: forward_jump_ms       <= cfg_data;
          REG_BACKWARD_TOL: backward_tolerance_ms <= cfg_data;
          default: ;
        endcase
      end
      if (wb_fire) begin
        result_valid <= 1'b1;
        anchor_su    <= anchor_su_next;
        anchor_ms    <= anchor_ms_next;
        last_auth    <= last_auth_next;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      op_mode <= item.mode;
      op_su   <= item.sender_units;
      op_now  <= item.session_now_ms;
      op_auth <= item.is_authority;
      op_need <= obs_need;
      op_div  <= obs_div || cnv_div;
      // delta against the last authority timestamp or the anchor
      diff    <= item.sender_units - ((item.mode == MODE_OBSERVE) ? last_auth : anchor_su);
    end
    if (wb_fire) result <= result_next;
  end

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV))
    else $error("divider result outside divide state");

  a_clear_unlocks: assert property (@(posedge clk) disable iff (rst)
    (wb_fire && op_mode == MODE_CLEAR) |=> (anchor_su[TS_W-1] && !result.locked))
    else $error("clear item left an anchor");

  a_reanchor_locked: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.reanchored) |-> (result.locked && result.session_ms == TS_NONE))
    else $error("reanchored result not locked or carries a time");

  a_wb_state_kept: assert property (@(posedge clk) disable iff (rst)
    (wb_fire && op_mode != MODE_OBSERVE && op_mode != MODE_CLEAR)
      |=> ($stable(anchor_su) && $stable(last_auth)))
    else $error("anchor changed outside observe or clear");

endmodule

### bench/timestamp_anchor_mapper_tb.sv
`timescale 1ns / 1ps
// timestamp_anchor_mapper_tb: self-checking bench for the timestamp anchor mapper
// depends on tam_pkg and the timestamp_anchor_mapper rtl; predicts each result in-bench
module timestamp_anchor_mapper_tb;
  import tam_pkg::*;

  localparam logic [1:0] MODE_NOP = 2'd3;
  localparam int LONG_HOLD = 600;
  localparam int TAIL_CYCLES = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  in_item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  out_item_t result;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_UNITS_PER_MS;
  logic [CFG_W-1:0] cfg_data = '0;

  // predictor copy of the block state and registers
  logic [63:0] anchor_units = TS_NONE;
  logic [63:0] anchor_sess = TS_NONE;
  logic [63:0] last_auth_units = TS_NONE;
  logic [31:0] units_per_ms_q = UNITS_PER_MS_RST;
  logic signed [31:0] fwd_jump_q = FORWARD_JUMP_RST;
  logic signed [31:0] bwd_tol_q = BACKWARD_TOL_RST;

  out_item_t expected_results[$];
  logic [63:0] session_clock = 64'd1000;
  int mismatch_count = 0;
  int items_sent = 0;
  int reanchors_seen = 0;
  int locked_conversions = 0;
  int settings_used = 1;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit long_hold = 1'b0;

  timestamp_anchor_mapper dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // signed units delta to ms, truncated toward zero
  function automatic logic [63:0] units_to_ms(input logic [63:0] d);
    logic [63:0] dv, mag, q;
    dv = (units_per_ms_q == 32'd0) ? 64'd1 : {32'd0, units_per_ms_q};
    mag = d[63] ? -d : d;
    q = mag / dv;
    return d[63] ? -q : q;
  endfunction

  function automatic out_item_t predict_mapping(input in_item_t it);
    out_item_t r;
    logic need;
    logic signed [63:0] dms;
    r.session_ms = TS_NONE;
    r.reanchored = 1'b0;
    case (it.mode)
      MODE_OBSERVE: begin
        if (!it.sender_units[63]) begin
          need = anchor_units[63] || (it.is_authority && it.discontinuity);
          if (!need && it.is_authority && !last_auth_units[63]) begin
            dms = units_to_ms(it.sender_units - last_auth_units);
            if (dms > fwd_jump_q || dms < bwd_tol_q) need = 1'b1;
          end
          if (need) begin
            anchor_units = it.sender_units;
            anchor_sess = it.session_now_ms;
            r.reanchored = 1'b1;
          end
          if (it.is_authority) last_auth_units = it.sender_units;
        end
      end
      MODE_CONVERT: begin
        if (!anchor_units[63] && !it.sender_units[63])
          r.session_ms = anchor_sess + units_to_ms(it.sender_units - anchor_units);
      end
      MODE_CLEAR: begin
        anchor_units = TS_NONE;
        anchor_sess = TS_NONE;
        last_auth_units = TS_NONE;
      end
      default: ;
    endcase
    r.locked = !anchor_units[63];
    return r;
  endfunction

  function automatic in_item_t mk(input logic [1:0] m, input logic [63:0] su,
                                  input logic [63:0] now, input logic d, input logic a);
    in_item_t it;
    it.mode = m;
    it.sender_units = su;
    it.session_now_ms = now;
    it.discontinuity = d;
    it.is_authority = a;
    return it;
  endfunction

  // mostly plausible timestamp streams around the current anchor, plus noise
  function automatic in_item_t next_item();
    in_item_t it;
    logic [31:0] r, r1, r2, upm_eff;
    logic [63:0] base, ms, frac;
    int pick;
    pick = $urandom_range(0, 99);
    r = $urandom;
    r1 = $urandom;
    r2 = $urandom;
    upm_eff = (units_per_ms_q == 32'd0) ? 32'd1 : units_per_ms_q;
    it = mk(MODE_OBSERVE, {2'b00, r1[29:0], r2}, session_clock, 1'b0, 1'b0);
    session_clock = session_clock + {58'd0, r[5:0]};
    if (pick < 45) begin
      base = last_auth_units[63] ? {2'b00, r1[29:0], r2} : last_auth_units;
      case (r[9:8])
        2'd0: ms = {58'd0, r[15:10]};
        2'd1: ms = {{32{fwd_jump_q[31]}}, fwd_jump_q} + {62'd0, r[17:16]} - 64'd1;
        2'd2: ms = {{32{bwd_tol_q[31]}}, bwd_tol_q} + {62'd0, r[17:16]} - 64'd2;
        default: ms = {{24{r1[31]}}, r1, r2[7:0]};
      endcase
      frac = r[18] ? {32'd0, $urandom_range(0, upm_eff - 32'd1)} : 64'd0;
      it.sender_units = base + ms * {32'd0, upm_eff} + frac;
      it.discontinuity = (r[23:19] == 5'd0);
      it.is_authority = 1'b1;
    end else if (pick < 60) begin
      if (!anchor_units[63]) it.sender_units = anchor_units + {{40{r1[23]}}, r1[23:0]};
      it.discontinuity = r[0];
    end else if (pick < 85) begin
      it.mode = MODE_CONVERT;
      if (!anchor_units[63] && r[1:0] != 2'd0)
        it.sender_units = anchor_units + {{32{r1[31]}}, r1};
      else
        it.sender_units = {r1, r2};
    end else if (pick < 90) begin
      it.mode = MODE_CLEAR;
    end else begin
      it.mode = r[1:0];
      it.sender_units = {r1, r2};
      it.session_now_ms = {$urandom, $urandom};
      it.discontinuity = r[2];
      it.is_authority = r[3];
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    out_item_t r;
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    r = predict_mapping(it);
    expected_results.push_back(r);
    items_sent++;
    if (r.reanchored) reanchors_seen++;
    if (it.mode == MODE_CONVERT && r.locked && !it.sender_units[63]) locked_conversions++;
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (tx_idle_en && $urandom_range(0, 4) == 0) begin
        item_valid <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      send_item(next_item());
    end
  endtask

  // sender stops until every expected result is back
  task automatic wait_results_done();
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input logic [31:0] upm, input logic [31:0] fwd,
                              input logic [31:0] bwd);
    cfg_we <= 1'b1;
    cfg_index <= REG_UNITS_PER_MS;
    cfg_data <= upm;
    @(posedge clk);
    cfg_index <= REG_FORWARD_JUMP;
    cfg_data <= fwd;
    @(posedge clk);
    cfg_index <= REG_BACKWARD_TOL;
    cfg_data <= bwd;
    @(posedge clk);
    cfg_we <= 1'b0;
    units_per_ms_q = upm;
    fwd_jump_q = fwd;
    bwd_tol_q = bwd;
    settings_used++;
  endtask

  // reset defaults: 90 units/ms, window [-200, 1000]
  task automatic test_defaults_directed();
    send_item(mk(MODE_CONVERT, 64'd100, 64'd0, 1'b0, 1'b0));
    send_item(mk(MODE_OBSERVE, 64'h8000_0000_0000_0000, 64'd5, 1'b0, 1'b1));
    send_item(mk(MODE_OBSERVE, 64'd9000, 64'd50, 1'b0, 1'b0));
    send_item(mk(MODE_CONVERT, 64'd9630, 64'd0, 1'b0, 1'b0));
    send_item(mk(MODE_CONVERT, 64'd0, 64'd0, 1'b0, 1'b0));
    send_item(mk(MODE_CONVERT, TS_NONE, 64'd0, 1'b0, 1'b0));
    send_item(mk(MODE_OBSERVE, 64'd9090, 64'd60, 1'b0, 1'b1));
    send_item(mk(MODE_OBSERVE, 64'd99090, 64'd1060, 1'b0, 1'b1));
    send_item(mk(MODE_OBSERVE, 64'd189179, 64'd2060, 1'b0, 1'b1));
    send_item(mk(MODE_OBSERVE, 64'd279269, 64'd3061, 1'b0, 1'b1));
    send_item(mk(MODE_OBSERVE, 64'd261269, 64'd3100, 1'b0, 1'b1));
    send_item(mk(MODE_OBSERVE, 64'd243180, 64'd3200, 1'b0, 1'b1));
    send_item(mk(MODE_OBSERVE, 64'd225090, 64'd3300, 1'b0, 1'b1));
    send_item(mk(MODE_OBSERVE, 64'd225100, 64'd3400, 1'b1, 1'b1));
    send_item(mk(MODE_OBSERVE, 64'd5, 64'd3500, 1'b1, 1'b0));
    send_item(mk(MODE_OBSERVE, 64'd9_000_000_000_000_000, 64'd3600, 1'b0, 1'b0));
    send_item(mk(MODE_OBSERVE, 64'd225200, 64'd3700, 1'b0, 1'b1));
    send_item(mk(MODE_NOP, {$urandom, $urandom}, {$urandom, $urandom}, 1'b1, 1'b1));
    send_item(mk(MODE_CLEAR, 64'd0, 64'd0, 1'b0, 1'b0));
    send_item(mk(MODE_CONVERT, 64'd225200, 64'd0, 1'b0, 1'b0));
    send_item(mk(MODE_OBSERVE, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000,
                 1'b0, 1'b1));
    send_item(mk(MODE_CONVERT, 64'd0, 64'd0, 1'b0, 1'b0));
    send_item(mk(MODE_OBSERVE, 64'd0, 64'h7fff_ffff_ffff_ffff, 1'b0, 1'b1));
    send_item(mk(MODE_CONVERT, 64'h7fff_ffff_ffff_ffff, 64'd0, 1'b0, 1'b0));
    wait_results_done();
  endtask

  // divisor 1 and the widest window: only 64-bit sized deltas leave it
  task automatic test_extreme_window();
    write_config(32'd1, 32'h7fff_ffff, 32'h8000_0000);
    send_item(mk(MODE_OBSERVE, 64'd0, 64'd10, 1'b0, 1'b1));
    send_item(mk(MODE_OBSERVE, 64'h7fff_ffff_ffff_ffff, 64'd20, 1'b0, 1'b1));
    send_item(mk(MODE_OBSERVE, 64'd0, 64'd30, 1'b0, 1'b1));
    send_item(mk(MODE_OBSERVE, 64'h7fff_ffff, 64'd40, 1'b0, 1'b1));
    send_item(mk(MODE_OBSERVE, 64'd0, 64'd50, 1'b0, 1'b1));
    send_item(mk(MODE_OBSERVE, 64'h8000_0000, 64'd60, 1'b0, 1'b1));
    send_item(mk(MODE_CONVERT, 64'h7fff_ffff_ffff_ffff, 64'd0, 1'b0, 1'b0));
    send_item(mk(MODE_CONVERT, 64'd0, 64'd0, 1'b0, 1'b0));
    run_random(40);
    wait_results_done();
  endtask

  // a written divisor of zero acts as one; zero-width window
  task automatic test_zero_divisor();
    write_config(32'd0, 32'd0, 32'd0);
    send_item(mk(MODE_OBSERVE, 64'd1000, 64'd5, 1'b0, 1'b1));
    send_item(mk(MODE_OBSERVE, 64'd1000, 64'd6, 1'b0, 1'b1));
    send_item(mk(MODE_OBSERVE, 64'd1001, 64'd7, 1'b0, 1'b1));
    send_item(mk(MODE_OBSERVE, 64'd1000, 64'd8, 1'b0, 1'b1));
    send_item(mk(MODE_CONVERT, 64'd1234, 64'd0, 1'b0, 1'b0));
    run_random(40);
    wait_results_done();
  endtask

  // forward limit below backward limit: every checked authority re-anchors
  task automatic test_inverted_window();
    write_config(32'hffff_ffff, -32'sd5, 32'sd5);
    run_random(40);
    wait_results_done();
  endtask

  task automatic test_random_configs();
    for (int k = 0; k < 3; k++) begin
      write_config($urandom, $urandom, $urandom);
      run_random(30);
      wait_results_done();
    end
    write_config($urandom_range(1, 1000), $urandom_range(0, 5000), -$urandom_range(0, 500));
    run_random(40);
    wait_results_done();
  endtask

  // receiver stops long enough for the block to back up onto its input
  task automatic test_receiver_hold();
    write_config(UNITS_PER_MS_RST, FORWARD_JUMP_RST, BACKWARD_TOL_RST);
    tx_idle_en = 1'b0;
    long_hold = 1'b1;
    run_random(12);
    tx_idle_en = 1'b1;
    wait_results_done();
  endtask

  task automatic test_random_stream();
    run_random(150);
  endtask

  task automatic test_no_idle();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_random(80);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_defaults_directed();
    test_extreme_window();
    test_zero_divisor();
    test_inverted_window();
    test_random_configs();
    test_receiver_hold();
    test_random_stream();
    test_no_idle();
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run covered %0d items over %0d register settings", items_sent, settings_used);
    $display("  %0d re-anchors, %0d locked conversions, one long receiver stall",
             reanchors_seen, locked_conversions);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // receiver: random stall bursts, one long hold on request
  initial begin
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        result_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
        result_ready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        result_ready <= 1'b1;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_result
    out_item_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing pending, got %h", $time, result);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (result.session_ms !== want.session_ms) begin
          $display("%0t: session_ms expected %h got %h", $time, want.session_ms,
                   result.session_ms);
          mismatch_count++;
        end
        if (result.locked !== want.locked) begin
          $display("%0t: locked expected %b got %b", $time, want.locked, result.locked);
          mismatch_count++;
        end
        if (result.reanchored !== want.reanchored) begin
          $display("%0t: reanchored expected %b got %b", $time, want.reanchored,
                   result.reanchored);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
